@@ hdl/psd_pkg.sv @@
package psd_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int T_FRAC_BITS_DEF = 24;
   localparam int DIST_WIDTH = 25;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      END_INTERIOR = 2'd0,
      END_FIRST    = 2'd1,
      END_SECOND   = 2'd2
   } end_type;

   typedef struct packed {
      logic    t_fixed;
      logic    t_one;
      end_type end_code;
   } ctl_type;

endpackage

@@ hdl/point_segment_distance_3d.sv @@
// Channel   Ports                                   Direction
// request   req_valid, req_ready, req_seg_*, req_point_*   in
// response  rsp_valid, rsp_ready, rsp_distance, rsp_clamped_end  out
//
// One transfer per cycle is accepted while the queue has room; one result
// per cycle is delivered while rsp_ready is high. Data passes the front
// pipeline, the queue, division and offset, square root, then the output.
// Reset clears every valid bit and the queue; payload registers keep no reset.
// A stalled response holds the back pipeline; the queue lets the front keep going
// until it fills, and req_ready then drops.
module point_segment_distance_3d import psd_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_seg_a_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_a_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg_a_z,
   input  logic signed [COORD_WIDTH-1:0] req_seg_b_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_b_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg_b_z,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [DIST_WIDTH-1:0]         rsp_distance,
   output logic [1:0]                    rsp_clamped_end
);

   localparam int CW = COORD_WIDTH;
   localparam int SW = 2 * (CW + 1) + 2;
   localparam int QW = 6 * (CW + 1) + 2 * SW + $bits(ctl_type);

   logic q_full, q_push, q_pop, q_not_empty;
   logic [QW-1:0] q_in, q_out;
   logic [2:0][CW:0] f_d, f_w, b_d, b_w;
   logic [SW-1:0] f_den, f_num, b_den, b_num;
   ctl_type f_ctl, b_ctl;

   psd_front #(.CW(CW)) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_seg_a_x(req_seg_a_x),
      .req_seg_a_y(req_seg_a_y),
      .req_seg_a_z(req_seg_a_z),
      .req_seg_b_x(req_seg_b_x),
      .req_seg_b_y(req_seg_b_y),
      .req_seg_b_z(req_seg_b_z),
      .req_point_x(req_point_x),
      .req_point_y(req_point_y),
      .req_point_z(req_point_z),
      .q_full(q_full),
      .out_push(q_push),
      .out_d(f_d),
      .out_w(f_w),
      .out_den(f_den),
      .out_num(f_num),
      .out_ctl(f_ctl)
   );

   assign q_in = {f_d, f_w, f_den, f_num, f_ctl};

   psd_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(q_in),
      .full(q_full),
      .pop(q_pop),
      .pop_data(q_out),
      .not_empty(q_not_empty)
   );

   assign {b_d, b_w, b_den, b_num, b_ctl} = q_out;

   psd_back #(.CW(CW), .TF(T_FRAC_BITS)) u_back (
      .clock(clock),
      .reset(reset),
      .in_valid(q_not_empty),
      .in_pop(q_pop),
      .in_d(b_d),
      .in_w(b_w),
      .in_den(b_den),
      .in_num(b_num),
      .in_ctl(b_ctl),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_distance(rsp_distance),
      .rsp_clamped_end(rsp_clamped_end)
   );

endmodule

@@ hdl/psd_queue.sv @@
module psd_queue import psd_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[tail_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[head_ff];
   assign full = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);

endmodule

@@ hdl/psd_front.sv @@
module psd_front import psd_pkg::*; #(
   parameter int CW = COORD_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [CW-1:0]        req_seg_a_x,
   input  logic signed [CW-1:0]        req_seg_a_y,
   input  logic signed [CW-1:0]        req_seg_a_z,
   input  logic signed [CW-1:0]        req_seg_b_x,
   input  logic signed [CW-1:0]        req_seg_b_y,
   input  logic signed [CW-1:0]        req_seg_b_z,
   input  logic signed [CW-1:0]        req_point_x,
   input  logic signed [CW-1:0]        req_point_y,
   input  logic signed [CW-1:0]        req_point_z,
   input  logic                        q_full,
   output logic                        out_push,
   output logic [2:0][CW:0]            out_d,
   output logic [2:0][CW:0]            out_w,
   output logic [2*(CW+1)+1:0]         out_den,
   output logic [2*(CW+1)+1:0]         out_num,
   output ctl_type                     out_ctl
);

   localparam int MW = CW + 1;
   localparam int PW = 2 * MW;
   localparam int SW = PW + 2;

   logic en;
   logic [2:0][CW-1:0] a_c, b_c, p_c;
   logic [2:0][CW:0] d_in, w_in;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [2:0][CW:0] d1_ff, w1_ff, d2_ff, w2_ff, d3_ff, w3_ff, d4_ff, w4_ff, d5_ff, w5_ff;
   logic [2:0][PW-1:0] dd2_ff, dw2_ff;
   logic [2:0] neg2_ff;
   logic [SW-1:0] den3_ff, pos3_ff, neg3_ff;
   logic [SW:0] diff4;
   logic [SW-1:0] den4_ff, num4_ff, den5_ff, num5_ff;
   logic zero4_ff, negf4_ff;
   ctl_type ctl5_in, ctl5_ff;
   logic [2:0][MW-1:0] dm, wm;
   logic [SW-1:0] den3_in, pos3_in, neg3_in;

   function automatic logic [CW:0] mag(input logic [CW:0] v);
      mag = v[CW] ? (~v + 1'b1) : v;
   endfunction

   assign en = !q_full;
   assign req_ready = en;

   assign a_c = {req_seg_a_z, req_seg_a_y, req_seg_a_x};
   assign b_c = {req_seg_b_z, req_seg_b_y, req_seg_b_x};
   assign p_c = {req_point_z, req_point_y, req_point_x};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d_in[k] = {b_c[k][CW-1], b_c[k]} - {a_c[k][CW-1], a_c[k]};
         w_in[k] = {p_c[k][CW-1], p_c[k]} - {a_c[k][CW-1], a_c[k]};
         dm[k] = mag(d1_ff[k]);
         wm[k] = mag(w1_ff[k]);
      end
   end

   always_comb begin
      den3_in = '0;
      pos3_in = '0;
      neg3_in = '0;
      for (int k = 0; k < 3; k++) begin
         den3_in = den3_in + SW'(dd2_ff[k]);
         if (neg2_ff[k]) begin
            neg3_in = neg3_in + SW'(dw2_ff[k]);
         end else begin
            pos3_in = pos3_in + SW'(dw2_ff[k]);
         end
      end
   end

   assign diff4 = {1'b0, pos3_ff} - {1'b0, neg3_ff};

   always_comb begin
      ctl5_in.t_fixed = 1'b0;
      ctl5_in.t_one = 1'b0;
      ctl5_in.end_code = END_INTERIOR;
      if (zero4_ff || negf4_ff) begin
         ctl5_in.t_fixed = 1'b1;
         ctl5_in.end_code = END_FIRST;
      end else if (num4_ff >= den4_ff) begin
         ctl5_in.t_fixed = 1'b1;
         ctl5_in.t_one = 1'b1;
         ctl5_in.end_code = (num4_ff == den4_ff) ? END_INTERIOR : END_SECOND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff <= d_in;
         w1_ff <= w_in;
         for (int k = 0; k < 3; k++) begin
            dd2_ff[k] <= PW'(dm[k]) * PW'(dm[k]);
            dw2_ff[k] <= PW'(wm[k]) * PW'(dm[k]);
            neg2_ff[k] <= d1_ff[k][CW] ^ w1_ff[k][CW];
         end
         d2_ff <= d1_ff;
         w2_ff <= w1_ff;
         den3_ff <= den3_in;
         pos3_ff <= pos3_in;
         neg3_ff <= neg3_in;
         d3_ff <= d2_ff;
         w3_ff <= w2_ff;
         num4_ff <= diff4[SW-1:0];
         negf4_ff <= diff4[SW];
         zero4_ff <= (den3_ff == '0);
         den4_ff <= den3_ff;
         d4_ff <= d3_ff;
         w4_ff <= w3_ff;
         ctl5_ff <= ctl5_in;
         num5_ff <= num4_ff;
         den5_ff <= den4_ff;
         d5_ff <= d4_ff;
         w5_ff <= w4_ff;
      end
   end

   assign out_push = v5_ff && en;
   assign out_d = d5_ff;
   assign out_w = w5_ff;
   assign out_den = den5_ff;
   assign out_num = num5_ff;
   assign out_ctl = ctl5_ff;

endmodule

@@ hdl/psd_back.sv @@
module psd_back import psd_pkg::*; #(
   parameter int CW = COORD_WIDTH_DEF,
   parameter int TF = T_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_pop,
   input  logic [2:0][CW:0]        in_d,
   input  logic [2:0][CW:0]        in_w,
   input  logic [2*(CW+1)+1:0]     in_den,
   input  logic [2*(CW+1)+1:0]     in_num,
   input  ctl_type                 in_ctl,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [DIST_WIDTH-1:0]   rsp_distance,
   output logic [1:0]              rsp_clamped_end
);

   localparam int MW = CW + 1;
   localparam int SW = 2 * MW + 2;
   localparam int EM = CW + 2;
   localparam int SQW = 2 * EM + 2;
   localparam int RB = SQW / 2;
   localparam int XW = (RB > DIST_WIDTH) ? RB : DIST_WIDTH;
   localparam int OW = MW + TF + 1;

   logic en;

   logic              vd_ff [TF+1];
   logic [SW-1:0]     r_ff [TF+1];
   logic [SW-1:0]     r_in [TF];
   logic [SW-1:0]     den_ff [TF+1];
   logic [TF:0]       t_ff [TF+1];
   logic [TF:0]       t_in [TF];
   logic              fix_ff [TF+1];
   end_type           endd_ff [TF+1];
   logic [2:0][CW:0]  dd_ff [TF+1];
   logic [2:0][CW:0]  wd_ff [TF+1];

   logic m1_v_ff, m2_v_ff, m3_v_ff, m4_v_ff;
   end_type m1_end_ff, m2_end_ff, m3_end_ff, m4_end_ff;
   logic [2:0][MW-1:0] m1_ff;
   logic [2:0] m1_sign_ff;
   logic [2:0][CW:0] m1_w_ff;
   logic [2:0][EM-1:0] e2_ff;
   logic [2:0][EM-1:0] e2_in;
   logic [2:0][2*EM-1:0] sq3_ff;
   logic [SQW-1:0] sq4_ff;
   logic [2:0][MW-1:0] dmag;
   logic [2:0][OW-1:0] prod;

   logic              vs_ff [RB+1];
   logic [SQW-1:0]    rem_ff [RB+1];
   logic [RB-1:0]     res_ff [RB+1];
   end_type           ends_ff [RB+1];
   logic [SQW-1:0]    rem_in [RB];
   logic [RB-1:0]     res_in [RB];

   logic rsp_valid_ff;
   logic [DIST_WIDTH-1:0] rsp_distance_ff;
   end_type rsp_end_ff;
   logic [XW-1:0] res_x;

   function automatic logic [CW:0] mag(input logic [CW:0] v);
      mag = v[CW] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [EM-1:0] mag_e(input logic [EM-1:0] v);
      mag_e = v[EM-1] ? (~v + 1'b1) : v;
   endfunction

   assign en = !rsp_valid_ff || rsp_ready;
   assign in_pop = en && in_valid;

   always_comb begin
      logic [SW:0] rs;
      for (int s = 0; s < TF; s++) begin
         rs = {r_ff[s], 1'b0};
         r_in[s] = r_ff[s];
         t_in[s] = t_ff[s];
         if (!fix_ff[s]) begin
            if (rs >= {1'b0, den_ff[s]}) begin
               r_in[s] = SW'(rs - {1'b0, den_ff[s]});
               t_in[s] = {t_ff[s][TF-1:0], 1'b1};
            end else begin
               r_in[s] = rs[SW-1:0];
               t_in[s] = {t_ff[s][TF-1:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      logic [EM-1:0] off;
      for (int k = 0; k < 3; k++) begin
         dmag[k] = mag(dd_ff[TF][k]);
         prod[k] = OW'(dmag[k]) * OW'(t_ff[TF]);
         off = m1_sign_ff[k] ? (~{1'b0, m1_ff[k]} + 1'b1) : {1'b0, m1_ff[k]};
         e2_in[k] = {m1_w_ff[k][CW], m1_w_ff[k]} - off;
      end
   end

   always_comb begin
      logic [SQW-1:0] trial;
      for (int j = 0; j < RB; j++) begin
         trial = (SQW'(res_ff[j]) << (RB - j)) | (SQW'(1) << (2 * (RB - 1 - j)));
         rem_in[j] = rem_ff[j];
         res_in[j] = res_ff[j];
         if (rem_ff[j] >= trial) begin
            rem_in[j] = rem_ff[j] - trial;
            res_in[j] = res_ff[j] | (RB'(1) << (RB - 1 - j));
         end
      end
   end

   assign res_x = XW'(res_ff[RB]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= TF; s++) begin
            vd_ff[s] <= 1'b0;
         end
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         m3_v_ff <= 1'b0;
         m4_v_ff <= 1'b0;
         for (int j = 0; j <= RB; j++) begin
            vs_ff[j] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vd_ff[0] <= in_valid;
         for (int s = 0; s < TF; s++) begin
            vd_ff[s+1] <= vd_ff[s];
         end
         m1_v_ff <= vd_ff[TF];
         m2_v_ff <= m1_v_ff;
         m3_v_ff <= m2_v_ff;
         m4_v_ff <= m3_v_ff;
         vs_ff[0] <= m4_v_ff;
         for (int j = 0; j < RB; j++) begin
            vs_ff[j+1] <= vs_ff[j];
         end
         rsp_valid_ff <= vs_ff[RB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0] <= in_num;
         den_ff[0] <= in_den;
         t_ff[0] <= in_ctl.t_one ? (TF+1)'(1) << TF : '0;
         fix_ff[0] <= in_ctl.t_fixed;
         endd_ff[0] <= in_ctl.end_code;
         dd_ff[0] <= in_d;
         wd_ff[0] <= in_w;
         for (int s = 0; s < TF; s++) begin
            r_ff[s+1] <= r_in[s];
            t_ff[s+1] <= t_in[s];
            den_ff[s+1] <= den_ff[s];
            fix_ff[s+1] <= fix_ff[s];
            endd_ff[s+1] <= endd_ff[s];
            dd_ff[s+1] <= dd_ff[s];
            wd_ff[s+1] <= wd_ff[s];
         end
         for (int k = 0; k < 3; k++) begin
            m1_ff[k] <= prod[k][TF +: MW];
            m1_sign_ff[k] <= dd_ff[TF][k][CW];
            e2_ff[k] <= e2_in[k];
            sq3_ff[k] <= (2*EM)'(mag_e(e2_ff[k])) * (2*EM)'(mag_e(e2_ff[k]));
         end
         m1_w_ff <= wd_ff[TF];
         m1_end_ff <= endd_ff[TF];
         m2_end_ff <= m1_end_ff;
         m3_end_ff <= m2_end_ff;
         sq4_ff <= SQW'(sq3_ff[0]) + SQW'(sq3_ff[1]) + SQW'(sq3_ff[2]);
         m4_end_ff <= m3_end_ff;
         rem_ff[0] <= sq4_ff;
         res_ff[0] <= '0;
         ends_ff[0] <= m4_end_ff;
         for (int j = 0; j < RB; j++) begin
            rem_ff[j+1] <= rem_in[j];
            res_ff[j+1] <= res_in[j];
            ends_ff[j+1] <= ends_ff[j];
         end
         rsp_distance_ff <= (res_x > XW'({DIST_WIDTH{1'b1}})) ?
                            {DIST_WIDTH{1'b1}} : DIST_WIDTH'(res_x);
         rsp_end_ff <= ends_ff[RB];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_clamped_end = rsp_end_ff;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import psd_pkg::*;

   localparam int CW = 24;
   localparam int TF = 24;
   localparam int PIPE_CYCLES = 5 + 4 + TF + 5 + CW + 5 + 8;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      logic signed [CW-1:0] c[9];
   } query_type;

   typedef struct {
      logic [DIST_WIDTH-1:0] distance;
      end_type               end_code;
   } answer_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic signed [CW-1:0]  req_c[9];
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [DIST_WIDTH-1:0] rsp_distance;
   logic [1:0]            rsp_clamped_end;

   query_type  pending_queries[$];
   answer_type expected_answers[$];
   int      error_count = 0;
   int      send_idle_pct = 18;
   int      recv_idle_pct = 76;
   int      hold_off_cycles = 0;
   bit      pause_sender = 1'b0;
   int      quiet_cycles = 0;

   initial begin
      for (int i = 0; i < 9; i++) req_c[i] = '0;
   end

   point_segment_distance_3d dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_seg_a_x(req_c[0]), .req_seg_a_y(req_c[1]), .req_seg_a_z(req_c[2]),
      .req_seg_b_x(req_c[3]), .req_seg_b_y(req_c[4]), .req_seg_b_z(req_c[5]),
      .req_point_x(req_c[6]), .req_point_y(req_c[7]), .req_point_z(req_c[8]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_distance(rsp_distance), .rsp_clamped_end(rsp_clamped_end)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic answer_type segment_distance(query_type q);
      answer_type            r;
      logic signed [63:0]    d[3], w[3], e;
      logic signed [127:0]   dot;
      logic [127:0]          den, num, rem, sq, cand;
      logic [63:0]           t, m, root;
      den = '0;
      dot = '0;
      for (int k = 0; k < 3; k++) begin
         d[k] = 64'(q.c[3+k]) - 64'(q.c[k]);
         w[k] = 64'(q.c[6+k]) - 64'(q.c[k]);
         den += 128'(d[k] * d[k]);
         dot += 128'(signed'(w[k] * d[k]));
      end
      t = '0;
      if (den == 0 || dot < 0) begin
         r.end_code = END_FIRST;
      end else begin
         num = dot;
         if (num >= den) begin
            t = 64'(1) << TF;
            r.end_code = (num == den) ? END_INTERIOR : END_SECOND;
         end else begin
            rem = num;
            for (int i = 0; i < TF; i++) begin
               rem = rem << 1;
               t = t << 1;
               if (rem >= den) begin
                  rem -= den;
                  t[0] = 1'b1;
               end
            end
            r.end_code = END_INTERIOR;
         end
      end
      sq = '0;
      for (int k = 0; k < 3; k++) begin
         m = 64'((128'(d[k] < 0 ? -d[k] : d[k]) * 128'(t)) >> TF);
         e = w[k] - (d[k] < 0 ? -signed'(m) : signed'(m));
         sq += 128'(e * e);
      end
      root = '0;
      for (int i = 35; i >= 0; i--) begin
         cand = 128'(root | (64'(1) << i));
         if (sq >= cand * cand) root = root | (64'(1) << i);
      end
      if (root > 64'h1FFFFFF) root = 64'h1FFFFFF;
      r.distance = root[DIST_WIDTH-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   function automatic logic signed [CW-1:0] rand_coord(int mode);
      case (mode)
         0: return CW'($urandom);
         1: return CW'($urandom_range(0, 255) - 128);
         2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
         default: return CW'($urandom_range(0, 65535) - 32768);
      endcase
   endfunction

   task automatic push_query(query_type q);
      pending_queries.push_back(q);
   endtask

   task automatic add_directed();
      query_type q;
      for (int n = 0; n < 20; n++) begin
         for (int i = 0; i < 9; i++) q.c[i] = '0;
         case (n)
            0: ;
            1: for (int i = 0; i < 9; i++) q.c[i] = 24'sh7FFFFF;
            2: for (int i = 0; i < 9; i++) q.c[i] = 24'sh800000;
            3: begin
               for (int i = 0; i < 3; i++) q.c[i] = 24'sh800000;
               for (int i = 3; i < 9; i++) q.c[i] = 24'sh7FFFFF;
            end
            4: begin
               for (int i = 0; i < 3; i++) q.c[i] = 24'sh7FFFFF;
               for (int i = 6; i < 9; i++) q.c[i] = 24'sh800000;
               for (int i = 3; i < 6; i++) q.c[i] = 24'sh7FFFFF;
            end
            5: begin q.c[3] = 24'sd100; q.c[6] = 24'sd50; q.c[7] = 24'sd30; end
            6: begin q.c[3] = 24'sd100; q.c[6] = -24'sd50; q.c[7] = 24'sd30; end
            7: begin q.c[3] = 24'sd100; q.c[6] = 24'sd150; q.c[7] = 24'sd30; end
            8: begin q.c[3] = 24'sd100; q.c[7] = 24'sd30; end
            9: begin q.c[3] = 24'sd100; q.c[6] = 24'sd100; q.c[8] = -24'sd7; end
            10: begin q.c[3] = 24'sh7FFFFF; q.c[0] = 24'sh800000; q.c[7] = 24'sh7FFFFF; end
            11: begin q.c[0] = 24'sd5; q.c[3] = 24'sd5; q.c[6] = 24'sh800000; end
            12: begin
               q.c[4] = -24'sd3; q.c[5] = 24'sd7; q.c[7] = -24'sd1; q.c[8] = 24'sd2;
            end
            default: for (int i = 0; i < 9; i++) q.c[i] = rand_coord(n % 4);
         endcase
         push_query(q);
      end
   endtask

   task automatic add_random(int count);
      query_type q;
      int     mode;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(0, 3);
         for (int i = 0; i < 9; i++) q.c[i] = rand_coord(mode);
         if ($urandom_range(0, 15) == 0)
            for (int i = 0; i < 3; i++) q.c[3+i] = q.c[i];
         push_query(q);
      end
   endtask

   task automatic wait_drained();
      while (pending_queries.size() != 0 || req_valid || expected_answers.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            query_type q;
            for (int i = 0; i < 9; i++) q.c[i] = req_c[i];
            expected_answers.push_back(segment_distance(q));
         end
         if (pending_queries.size() != 0 && !pause_sender &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            query_type q;
            q = pending_queries.pop_front();
            for (int i = 0; i < 9; i++) req_c[i] <= q.c[i];
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               report_mismatch("unexpected result", longint'(rsp_distance), longint'(-1));
            end else begin
               answer_type a;
               a = expected_answers.pop_front();
               if (rsp_distance !== a.distance)
                  report_mismatch("distance", longint'(rsp_distance), longint'(a.distance));
               if (rsp_clamped_end !== a.end_code)
                  report_mismatch("clamped_end", longint'(rsp_clamped_end),
                                  longint'(a.end_code));
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      add_directed();
      add_random(630);
      wait_drained();
      pause_sender = 1'b1;
      repeat (3) @(posedge clock);
      pause_sender = 1'b0;
      send_idle_pct = 76;
      recv_idle_pct = 18;
      add_random(600);
      @(posedge clock);
      hold_off_cycles <= 400;
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random(700);
      @(posedge clock);
      hold_off_cycles <= 300;
      wait_drained();
      repeat (PIPE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
